// ----- rtl/core/dks_pkg.sv -----
// DES key schedule package: field widths, permuted choice tables and the
// helper functions used by the front and back modules.
// Depends on nothing.
package dks_pkg;

    localparam int KEY_W      = 64;
    localparam int HALF_W     = 28;
    localparam int CD_W       = 2 * HALF_W;
    localparam int SUBKEY_W   = 48;
    localparam int ROUND_W    = 4;
    localparam int ROUNDS     = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [ROUND_W-1:0] ROUND_FIRST = ROUND_W'(0);
    localparam logic [ROUND_W-1:0] ROUND_LAST  = ROUND_W'(ROUNDS - 1);

    // Both 28-bit halves of one key after the key permutation
    typedef struct packed {
        logic [HALF_W-1:0] c;
        logic [HALF_W-1:0] d;
    } t_halves;

    // Queue status seen by both neighbours
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Table entries are 1-based positions, position 1 being the MSB
    localparam logic [6:0] PC1_TAB [CD_W] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TAB [SUBKEY_W] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // Key permutation into C and D: pure wiring, parity bits dropped
    function automatic t_halves pc1(input logic [KEY_W-1:0] key);
        logic [CD_W-1:0] chosen;
        for (int i = 0; i < CD_W; i++) begin
            chosen[CD_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
        end
        return t_halves'(chosen);
    endfunction

    // Compression permutation over C:D
    function automatic logic [SUBKEY_W-1:0] pc2(input t_halves cd);
        logic [CD_W-1:0]     joined;
        logic [SUBKEY_W-1:0] chosen;
        joined = {cd.c, cd.d};
        for (int i = 0; i < SUBKEY_W; i++) begin
            chosen[SUBKEY_W-1-i] = joined[CD_W - int'(PC2_TAB[i])];
        end
        return chosen;
    endfunction

    // Single-place rotation in the first two rounds, the ninth and the last;
    // double elsewhere
    function automatic logic shift_two(input logic [ROUND_W-1:0] round);
        logic two;
        case (round)
            ROUND_W'(0), ROUND_W'(1), ROUND_W'(8), ROUND_LAST: two = 1'b0;
            default:                                          two = 1'b1;
        endcase
        return two;
    endfunction

    function automatic logic [HALF_W-1:0] rot_half(input logic [HALF_W-1:0] h,
                                                   input logic two);
        return two ? {h[HALF_W-3:0], h[HALF_W-1:HALF_W-2]}
                   : {h[HALF_W-2:0], h[HALF_W-1]};
    endfunction

endpackage

// ----- rtl/core/dks_front.sv -----
// Front end: take key beats, apply the key permutation and register the halves
// until the queue has room. Depends on dks_pkg.
module dks_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [dks_pkg::KEY_W-1:0] i_key,
    output logic                      o_full,
    input  dks_pkg::t_q_stat          i_q_stat,
    output logic                      o_q_push,
    output dks_pkg::t_halves          o_q_data
);
    import dks_pkg::*;

    logic    r_vld;
    logic    n_vld;
    t_halves r_cd;
    logic    w_take;
    logic    w_pass;

    assign w_pass = r_vld && !i_q_stat.full;
    assign o_full = r_vld && i_q_stat.full;
    assign w_take = i_push && !o_full;

    always_comb begin
        n_vld = r_vld;
        if (w_take) begin
            n_vld = 1'b1;
        end else if (w_pass) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cd <= pc1(i_key);
        end
    end

    assign o_q_push = w_pass;
    assign o_q_data = r_cd;

endmodule

// ----- rtl/core/dks_queue.sv -----
// Short queue of key-permuted C and D halves between front and back.
// Depends on dks_pkg.
module dks_queue #(
    parameter int DEPTH = dks_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dks_pkg::t_halves i_data,
    input  logic             i_pop,
    output dks_pkg::t_halves o_data,
    output dks_pkg::t_q_stat o_stat
);
    import dks_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_halves            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_wr = i_push && !o_stat.full;
    assign w_rd = i_pop && !o_stat.empty;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd_ptr];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a write");

endmodule

// ----- rtl/core/dks_back.sv -----
// Back end: round engine that rotates the halves and draws one subkey per
// cycle into the result register while it is not stalled. Depends on dks_pkg.
module dks_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dks_pkg::t_q_stat             i_q_stat,
    input  dks_pkg::t_halves             i_q_data,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [dks_pkg::SUBKEY_W-1:0] o_subkey,
    output logic [dks_pkg::ROUND_W-1:0]  o_round_number,
    output logic                         o_last
);
    import dks_pkg::*;

    logic                r_busy;
    logic [ROUND_W-1:0]  r_round;
    t_halves             r_cd;
    t_halves             n_cd;
    logic                r_out_vld;
    logic [SUBKEY_W-1:0] r_out_key;
    logic [ROUND_W-1:0]  r_out_round;
    logic                r_out_last;
    logic                w_adv;
    logic                w_end;
    logic                w_load;
    logic                w_two;

    assign w_adv  = r_busy && (!r_out_vld || i_pop);
    assign w_end  = w_adv && (r_round == ROUND_LAST);
    assign w_load = !i_q_stat.empty && (!r_busy || w_end);
    assign w_two  = shift_two(r_round);

    always_comb begin
        n_cd.c = rot_half(r_cd.c, w_two);
        n_cd.d = rot_half(r_cd.d, w_two);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_round   <= ROUND_FIRST;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy  <= 1'b1;
                r_round <= ROUND_FIRST;
            end else if (w_end) begin
                r_busy  <= 1'b0;
                r_round <= ROUND_FIRST;
            end else if (w_adv) begin
                r_round <= r_round + 1'b1;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cd <= i_q_data;
        end else if (w_adv) begin
            r_cd <= n_cd;
        end
        if (w_adv) begin
            r_out_key   <= pc2(n_cd);
            r_out_round <= r_round;
            r_out_last  <= (r_round == ROUND_LAST);
        end
    end

    assign o_q_pop        = w_load;
    assign o_empty        = !r_out_vld;
    assign o_subkey       = r_out_key;
    assign o_round_number = r_out_round;
    assign o_last         = r_out_last;

    a_idle_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_round == ROUND_FIRST))
        else $error("round counter left running while idle");

    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_last == (r_out_round == ROUND_LAST)))
        else $error("last flag out of step with round number");

    a_round_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_round != ROUND_LAST) |=> (r_busy && r_round == $past(r_round) + 1'b1))
        else $error("round skipped or engine dropped a run");

endmodule

// ----- rtl/core/des_key_schedule_unit.sv -----
// DES key schedule top level: front (key permutation), halves queue and
// round engine with result register. Depends on dks_pkg and the dks_* modules.
//
//  channel  | direction | handshake           | beat payload
//  ---------+-----------+---------------------+----------------------------------
//  key      | in        | i_push / o_full     | i_key (64 b, leftmost DES bit is MSB)
//  subkey   | out       | o_empty / i_pop     | o_subkey, o_round_number, o_last
//
//  Each key beat yields sixteen subkey beats, one per cycle while i_pop keeps
//  up; the round engine is the limit, so keys are taken at one per sixteen rounds.
//  Keys pass the front register, the queue and the engine on the way to the result.
//  Reset (synchronous, active low) empties front, queue and result register.
//  A stalled result holds the engine; the front and queue keep taking keys
//  until the queue and the front register are full, then o_full rises.
module des_key_schedule_unit #(
    parameter int QUEUE_DEPTH = dks_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [dks_pkg::KEY_W-1:0]    i_key,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [dks_pkg::SUBKEY_W-1:0] o_subkey,
    output logic [dks_pkg::ROUND_W-1:0]  o_round_number,
    output logic                         o_last
);
    import dks_pkg::*;

    // Front to queue: one beat of permuted halves
    logic    w_q_push;
    t_halves w_q_wdata;
    // Queue to back
    logic    w_q_pop;
    t_halves w_q_rdata;
    t_q_stat w_q_stat;

    // Take key beats, apply the key permutation, hold until the queue has room
    dks_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_key    (i_key),
        .o_full   (o_full),
        .i_q_stat (w_q_stat),
        .o_q_push (w_q_push),
        .o_q_data (w_q_wdata)
    );

    // Decouple front from the round engine so each side stalls on its own
    dks_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_stat  (w_q_stat)
    );

    // Advance sixteen rounds per key; the next key loads on the last round
    dks_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (w_q_stat),
        .i_q_data       (w_q_rdata),
        .o_q_pop        (w_q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_subkey       (o_subkey),
        .o_round_number (o_round_number),
        .o_last         (o_last)
    );

endmodule
